/* hdl/mrwt_pkg.sv */
package mrwt_pkg;

    localparam logic [1:0] VERDICT_PRIME     = 2'd0;
    localparam logic [1:0] VERDICT_COMPOSITE = 2'd1;
    localparam logic [1:0] VERDICT_INVALID   = 2'd2;

    // Operation codes for the shared modular unit.
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_REDUCE = 3'd1;
    localparam logic [2:0] OP_SHIFT  = 3'd2;
    localparam logic [2:0] OP_SQUARE = 3'd3;
    localparam logic [2:0] OP_MULA   = 3'd4;
    localparam logic [2:0] OP_IDLE   = 3'd5;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } mrwt_cmd_t;

    typedef struct packed {
        logic busy;
        logic invalid;
        logic e_bit;
        logic x_one;
        logic x_nm1;
        logic a_trivial;
        logic last_bit;
        logic s_done;
    } mrwt_stat_t;

endpackage

/* hdl/mrwt_datapath.sv */
module mrwt_datapath
    import mrwt_pkg::*;
#(
    parameter int NUM_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          candidate,
    input  logic [31:0]          witness,
    input  logic                 load,
    input  mrwt_cmd_t            cmd,
    output mrwt_stat_t           stat
);

    localparam int CW = $clog2(NUM_WIDTH + 1);
    localparam int BW = $clog2(NUM_WIDTH);

    logic [NUM_WIDTH-1:0] n_reg, a_reg, d_reg, x_reg, r_reg, mb_reg, ma_reg;
    logic [CW-1:0]        s_reg, j_reg;
    logic [BW-1:0]        ebit_reg, mbit_reg;
    logic [CW-1:0]        rcnt_reg;
    logic                 busy_reg, phase_reg;
    logic [2:0]           op_reg;

    // (p + q) mod n for p, q < n, without overflow.
    function automatic logic [NUM_WIDTH-1:0] add_mod(
        input logic [NUM_WIDTH-1:0] p,
        input logic [NUM_WIDTH-1:0] q,
        input logic [NUM_WIDTH-1:0] m
    );
        logic [NUM_WIDTH-1:0] room;
        begin
            room = m - q;
            add_mod = (p >= room) ? (p - room) : (p + q);
        end
    endfunction

    logic [NUM_WIDTH-1:0] nm1;
    logic [NUM_WIDTH-1:0] dbl, sum_a;
    assign nm1   = n_reg - 1'b1;
    assign dbl   = add_mod(r_reg, r_reg, n_reg);
    assign sum_a = add_mod(dbl, ma_reg, n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= '0;
            a_reg     <= '0;
            d_reg     <= '0;
            x_reg     <= '0;
            r_reg     <= '0;
            mb_reg    <= '0;
            ma_reg    <= '0;
            s_reg     <= '0;
            j_reg     <= '0;
            ebit_reg  <= '0;
            mbit_reg  <= '0;
            rcnt_reg  <= '0;
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            op_reg    <= OP_LOAD;
        end
        else
        begin
            if (load)
            begin
                n_reg    <= NUM_WIDTH'(candidate);
                a_reg    <= NUM_WIDTH'(witness);
                busy_reg <= 1'b0;
            end
            else if (cmd.start)
            begin
                op_reg <= cmd.op;
                case (cmd.op)
                    OP_REDUCE:
                    begin
                        // Witness mod n by restoring division, one bit a cycle.
                        r_reg    <= '0;
                        mb_reg   <= a_reg;
                        rcnt_reg <= CW'(NUM_WIDTH);
                        busy_reg <= 1'b1;
                    end
                    OP_SHIFT:
                    begin
                        d_reg    <= nm1;
                        s_reg    <= '0;
                        j_reg    <= CW'(1);
                        x_reg    <= {{(NUM_WIDTH-1){1'b0}}, 1'b1};
                        ebit_reg <= BW'(NUM_WIDTH - 1);
                        busy_reg <= 1'b1;
                    end
                    OP_SQUARE, OP_MULA:
                    begin
                        r_reg    <= '0;
                        ma_reg   <= x_reg;
                        mb_reg   <= (cmd.op == OP_SQUARE) ? x_reg : a_reg;
                        mbit_reg <= BW'(NUM_WIDTH - 1);
                        busy_reg <= 1'b1;
                        phase_reg <= 1'b0;
                    end
                    default:
                    begin
                        busy_reg <= 1'b0;
                    end
                endcase
            end
            else if (busy_reg)
            begin
                case (op_reg)
                    OP_REDUCE:
                    begin
                        if ({r_reg, mb_reg[NUM_WIDTH-1]} >= {1'b0, n_reg})
                            r_reg <= NUM_WIDTH'({r_reg, mb_reg[NUM_WIDTH-1]}
                                     - {1'b0, n_reg});
                        else
                            r_reg <= {r_reg[NUM_WIDTH-2:0], mb_reg[NUM_WIDTH-1]};
                        mb_reg   <= {mb_reg[NUM_WIDTH-2:0], 1'b0};
                        rcnt_reg <= rcnt_reg - 1'b1;
                        if (rcnt_reg == CW'(1))
                        begin
                            busy_reg <= 1'b0;
                            phase_reg <= 1'b1;
                        end
                    end
                    OP_SHIFT:
                    begin
                        if (!d_reg[0])
                        begin
                            d_reg <= d_reg >> 1;
                            s_reg <= s_reg + 1'b1;
                        end
                        else
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                    default:
                    begin
                        r_reg    <= mb_reg[mbit_reg] ? sum_a : dbl;
                        mbit_reg <= mbit_reg - 1'b1;
                        if (mbit_reg == '0)
                        begin
                            x_reg    <= mb_reg[mbit_reg] ? sum_a : dbl;
                            busy_reg <= 1'b0;
                        end
                    end
                endcase
            end
            else if (op_reg == OP_REDUCE && phase_reg)
            begin
                a_reg     <= r_reg;
                phase_reg <= 1'b0;
            end
            else if (cmd.op == OP_IDLE)
            begin
                // The exponent bits are stepped first; once they are used up,
                // each step counts one of the closing squarings.
                if (ebit_reg != '0)
                    ebit_reg <= ebit_reg - 1'b1;
                else
                    j_reg <= j_reg + 1'b1;
            end
        end
    end

    assign stat.busy      = busy_reg || (op_reg == OP_REDUCE && phase_reg);
    assign stat.invalid   = (n_reg < NUM_WIDTH'(5)) || !n_reg[0];
    assign stat.e_bit     = d_reg[ebit_reg];
    assign stat.last_bit  = (ebit_reg == '0);
    assign stat.x_one     = (x_reg == NUM_WIDTH'(1));
    assign stat.x_nm1     = (x_reg == nm1);
    assign stat.a_trivial = (a_reg <= NUM_WIDTH'(1)) || (a_reg == nm1);
    assign stat.s_done    = (j_reg >= s_reg);

endmodule

/* hdl/mrwt_ctrl.sv */
module mrwt_ctrl
    import mrwt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] verdict,
    output logic       load,
    output mrwt_cmd_t  cmd,
    input  mrwt_stat_t stat
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_RED   = 4'd2;
    localparam logic [3:0] ST_TRIV  = 4'd3;
    localparam logic [3:0] ST_SHIFT = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_SQW   = 4'd6;
    localparam logic [3:0] ST_MUW   = 4'd7;
    localparam logic [3:0] ST_NEXT  = 4'd8;
    localparam logic [3:0] ST_TEST  = 4'd9;
    localparam logic [3:0] ST_LSQ   = 4'd10;
    localparam logic [3:0] ST_LSQW  = 4'd11;
    localparam logic [3:0] ST_LTEST = 4'd12;
    localparam logic [3:0] ST_WAIT1 = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] verdict_reg, verdict_next;

    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign load      = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        verdict_next   = verdict_reg;
        cmd.start      = 1'b0;
        cmd.op         = OP_LOAD;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.invalid)
                begin
                    verdict_next = VERDICT_INVALID;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.start = 1'b1;
                    cmd.op = OP_REDUCE;
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                if (!stat.busy)
                    state_next = ST_TRIV;
            end
            ST_TRIV:
            begin
                if (stat.a_trivial)
                begin
                    verdict_next = VERDICT_PRIME;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.start = 1'b1;
                    cmd.op = OP_SHIFT;
                    state_next = ST_WAIT1;
                end
            end
            ST_WAIT1:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (!stat.busy)
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.start = 1'b1;
                cmd.op = OP_SQUARE;
                state_next = ST_SQW;
            end
            ST_SQW:
            begin
                if (!stat.busy)
                begin
                    if (stat.e_bit)
                    begin
                        cmd.start = 1'b1;
                        cmd.op = OP_MULA;
                        state_next = ST_MUW;
                    end
                    else
                        state_next = ST_NEXT;
                end
            end
            ST_MUW:
            begin
                if (!stat.busy)
                    state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (stat.last_bit)
                    state_next = ST_TEST;
                else
                begin
                    cmd.op = OP_IDLE;
                    state_next = ST_SQ;
                end
            end
            ST_TEST:
            begin
                if (stat.x_one || stat.x_nm1)
                begin
                    verdict_next = VERDICT_PRIME;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_LTEST;
            end
            ST_LTEST:
            begin
                if (stat.s_done)
                begin
                    verdict_next = VERDICT_COMPOSITE;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.start = 1'b1;
                    cmd.op = OP_SQUARE;
                    state_next = ST_LSQW;
                end
            end
            ST_LSQW:
            begin
                if (!stat.busy)
                    state_next = ST_LSQ;
            end
            ST_LSQ:
            begin
                if (stat.x_nm1)
                begin
                    verdict_next = VERDICT_PRIME;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.x_one)
                begin
                    verdict_next = VERDICT_COMPOSITE;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.op = OP_IDLE;
                    state_next = ST_LTEST;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            verdict_reg   <= VERDICT_PRIME;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            verdict_reg   <= verdict_next;
        end
    end

endmodule

/* hdl/miller_rabin_witness_test_top.sv */
// Channel   Direction  Handshake            Fields
// input     in         in_valid/in_stall    candidate[31:0], witness[31:0]
// output    out        out_valid/out_stall  verdict[1:0]
//
// One word in, one word out; the next word is taken once the verdict has left.
// The single shared modular unit does the work in turn: it reduces the witness mod n, splits n-1
// into d and s, then per exponent bit of d squares, multiplies by the witness if the bit is set
// and steps, then does up to s-1 closing squarings.
// Reset clears the controller, the output valid and the datapath registers.
// A stalled verdict holds until taken.
module miller_rabin_witness_test_top
    import mrwt_pkg::*;
#(
    parameter int NUM_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] candidate,
    input  logic [31:0] witness,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict
);

    logic       load;
    mrwt_cmd_t  cmd;
    mrwt_stat_t stat;

    mrwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict),
        .load      (load),
        .cmd       (cmd),
        .stat      (stat)
    );

    mrwt_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (candidate),
        .witness   (witness),
        .load      (load),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* sim/mrwt_checker.sv */
module mrwt_checker
    import mrwt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] candidate,
    input  logic [31:0] witness,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  verdict,
    output int          fail_count,
    output int          pending
);

    logic [1:0] verdict_queue[$];

    function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [63:0] room;
        room = n - b;
        return (a >= room) ? (a - room) : (a + b);
    endfunction

    function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [63:0] r;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            r = mod_add(r, r, n);
            if (b[i])
                r = mod_add(r, a, n);
        end
        return r;
    endfunction

    function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e,
                                            logic [63:0] n);
        logic [63:0] y;
        y = 1;
        for (int i = 31; i >= 0; i--)
        begin
            y = mod_mul(y, y, n);
            if (e[i])
                y = mod_mul(y, base, n);
        end
        return y;
    endfunction

    function automatic logic [1:0] predict_verdict(logic [31:0] cand, logic [31:0] wit);
        logic [63:0] n;
        logic [63:0] a;
        logic [63:0] d;
        logic [63:0] x;
        int          s;
        n = cand;
        a = wit;
        if (n < 5 || !n[0])
            return VERDICT_INVALID;
        a = a % n;
        if (a <= 1 || a == n - 1)
            return VERDICT_PRIME;
        d = n - 1;
        s = 0;
        while (!d[0])
        begin
            d = d >> 1;
            s++;
        end
        x = mod_pow(a, d, n);
        if (x == 1 || x == n - 1)
            return VERDICT_PRIME;
        for (int j = 1; j < s; j++)
        begin
            x = mod_mul(x, x, n);
            if (x == n - 1)
                return VERDICT_PRIME;
            if (x == 1)
                return VERDICT_COMPOSITE;
        end
        return VERDICT_COMPOSITE;
    endfunction

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                verdict_queue = {verdict_queue, predict_verdict(candidate, witness)};
            if (out_valid && !out_stall)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $error("verdict word with nothing expected: actual %0d", verdict);
                    fail_count++;
                end
                else
                begin
                    if (verdict !== verdict_queue[0])
                    begin
                        $error("verdict mismatch: expected %0d actual %0d",
                               verdict_queue[0], verdict);
                        fail_count++;
                    end
                    void'(verdict_queue.pop_front());
                end
            end
            pending = verdict_queue.size();
        end
    end

endmodule

/* sim/tb_miller_rabin_witness_test_top.sv */
module tb_miller_rabin_witness_test_top;

    localparam int CYCLE_LIMIT = 4000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] candidate;
    logic [31:0] witness;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  verdict;
    int          fail_count;
    int          pending;
    int          cycle_count;
    bit          calm;

    miller_rabin_witness_test_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .candidate(candidate), .witness(witness), .out_valid(out_valid),
        .out_stall(out_stall), .verdict(verdict)
    );

    mrwt_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .candidate(candidate), .witness(witness), .out_valid(out_valid),
        .out_stall(out_stall), .verdict(verdict), .fail_count(fail_count),
        .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_miller_rabin_witness_test_top NOT OK");
            $finish;
        end
    end

    // Receiver stalls in random bursts until the calm tail of the run.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            repeat ($urandom_range(1, 16)) @(negedge clk);
            out_stall <= !calm && ($urandom_range(0, 2) == 0);
        end
    end

    // Called at a falling edge; returns at the falling edge after the word was taken.
    // Valid stays high between words unless an idle gap is drawn.
    task automatic send_word(input logic [31:0] n, input logic [31:0] a);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        candidate <= n;
        witness   <= a;
        in_valid  <= 1'b1;
        while (in_stall)
            @(negedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_odd(int bits);
        logic [31:0] v;
        v = $urandom();
        if (bits < 32)
            v = v & ((32'd1 << bits) - 1);
        return v | 32'd1;
    endfunction

    initial
    begin
        logic [31:0] n;
        logic [31:0] a;
        cycle_count = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        candidate = '0;
        witness = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Invalid, trivial witnesses, out of range witnesses, known primes and composites.
        send_word(32'd0, 32'd2);
        send_word(32'd3, 32'd2);
        send_word(32'd4, 32'd2);
        send_word(32'hFFFF_FFFE, 32'd3);
        send_word(32'd5, 32'd2);
        send_word(32'd7, 32'd0);
        send_word(32'd7, 32'd1);
        send_word(32'd7, 32'd6);
        send_word(32'd7, 32'd15);
        send_word(32'd561, 32'd2);
        send_word(32'd2047, 32'd2);
        send_word(32'd221, 32'd174);
        send_word(32'd221, 32'd137);
        send_word(32'hFFFF_FFFB, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFD);
        send_word(32'hFFFF_FFFB, 32'h1234_5678);
        send_word(32'd3215031751, 32'd2);
        send_word(32'h8000_0001, 32'h5555_5555);
        send_word(32'hFFFF_FFFF, 32'hAAAA_AAAA);
        in_valid <= 1'b0;

        // Hold off until the block has drained everything.
        while (pending != 0)
            @(negedge clk);

        for (int i = 0; i < 150; i++)
        begin
            if (i == 120)
                calm = 1'b1;
            case ($urandom_range(0, 9))
                0: n = $urandom();
                1: n = $urandom_range(0, 12);
                2: n = random_odd($urandom_range(3, 12));
                default: n = random_odd($urandom_range(8, 32));
            endcase
            case ($urandom_range(0, 5))
                0: a = $urandom();
                1: a = $urandom_range(0, 3);
                2: a = n - $urandom_range(0, 3);
                default: a = (n > 4) ? $urandom_range(2, n - 3) : $urandom();
            endcase
            send_word(n, a);
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("tb_miller_rabin_witness_test_top OK");
        else
            $display("tb_miller_rabin_witness_test_top NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
hdl/mrwt_pkg.sv
hdl/mrwt_datapath.sv
hdl/mrwt_ctrl.sv
hdl/miller_rabin_witness_test_top.sv
sim/mrwt_checker.sv
sim/tb_miller_rabin_witness_test_top.sv
